>>> rtl/ultrasonic_echo_ranger_macros.svh
// assertion macros used by the checker file
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// same-cycle implication, quiet during reset
`define UER_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ultrasonic_echo_ranger check failed");

// next-cycle implication, quiet during reset
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ultrasonic_echo_ranger check failed");

`endif

>>> rtl/uer_pkg.sv
package uer_pkg;

  // field and datapath widths
  localparam int unsigned COUNT_W     = 17;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned DIST_W      = 19;
  localparam int unsigned PROD1_W     = COUNT_W + GAIN_W;
  localparam int unsigned MUL_W       = PROD1_W + GAIN_W;
  localparam int unsigned PROD_W      = 44;
  localparam int unsigned SCALE_SHIFT = 22;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_DATA_W   = 8;
  localparam int unsigned OUT_DATA_W  = 24;

  // fixed-point scale: 0.0343 / 2 * 256 / 16384 ~ 1124 / 2^22
  localparam logic [GAIN_W-1:0]  SCALE_MUL       = 16'd1124;
  localparam logic [DIST_W-1:0]  DIST_MAX        = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
  localparam logic [COUNT_W-1:0] TRIG_LOW_TICKS  = 17'd2;
  localparam logic [COUNT_W-1:0] TRIG_HIGH_TICKS = 17'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;
  localparam logic [GAIN_W-1:0]    GAIN_RESET    = 16'd16384;
  localparam logic [GAIN_W-1:0]    TIMEOUT_RESET = 16'd25000;

  // status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_ECHO  = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  // measurement phase
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_RISE = 3'd3,
    PH_MEASURE   = 3'd4
  } phase_t;

  // item sequencer
  typedef enum logic [2:0] {
    SEQ_IDLE      = 3'd0,
    SEQ_MUL_GAIN  = 3'd1,
    SEQ_MUL_SCALE = 3'd2,
    SEQ_SAT       = 3'd3,
    SEQ_OUT       = 3'd4
  } seq_t;

  // outcome of one tick, from the phase controller to the sequencer
  typedef struct packed {
    logic               trig;
    logic               busy;
    logic               done;
    logic [1:0]         status;
    logic               calc;
    logic [COUNT_W-1:0] ticks;
  } step_t;

endpackage

>>> rtl/ultrasonic_echo_ranger.sv
// channel  | direction | signals                        | contents
// in_      | slave     | in_tvalid/in_tready/in_tdata   | one microsecond tick
// out_     | master    | out_tvalid/out_tready/out_tdata| one result per tick
// cfg_     | slave     | cfg_valid/cfg_ready/index/data | register write, always ready
//
// A tick that ends no pulse is offered on out_ from the cycle after its transfer;
// the next tick may transfer in the same cycle as that result, so ticks can stream back to back while out_ is ready.
// A tick that closes an echo pulse makes two passes through the one
// shared 33x16 multiplier (ticks*gain, then *1124), a saturation step, then out_.
// Reset (rst_n low, synchronous) gives idle, gain 16384, timeout 25000, distance 0.
// out_ stalls hold the result and block further input transfers.
module ultrasonic_echo_ranger (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [0] start_request, [1] echo_level, [7:2] zero
  input  logic [uer_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] trigger_level, [1] busy_res, [2] done_res, [4:3] status, [23:5] distance_q8
  output logic [uer_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::GAIN_W-1:0]     cfg_data
);
  import uer_pkg::*;

  seq_t               seq_r, seq_nxt;
  logic [GAIN_W-1:0]  gain_r;
  logic [GAIN_W-1:0]  timeout_r;
  logic [DIST_W-1:0]  last_dist_r;
  logic [COUNT_W-1:0] ticks_r;
  logic               res_trig_r;
  logic               res_busy_r;
  logic               res_done_r;
  logic [1:0]         res_status_r;
  logic               in_xfer;
  logic               cfg_xfer;
  logic               mul_en;
  logic               mul_sel_scale;
  logic               dist_load;
  logic [PROD_W-1:0]  prod;
  logic [DIST_W-1:0]  dist_sat;
  step_t              step;

  assign in_tready  = (seq_r == SEQ_IDLE) || ((seq_r == SEQ_OUT) && out_tready);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = (seq_r == SEQ_OUT);
  assign out_tdata  = {last_dist_r, res_status_r, res_done_r, res_busy_r, res_trig_r};
  assign cfg_ready  = 1'b1;
  assign cfg_xfer   = cfg_valid && cfg_ready;

  // tick phase controller
  uer_phase_ctrl u_phase (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_xfer),
    .start   (in_tdata[0]),
    .echo    (in_tdata[1]),
    .timeout (timeout_r),
    .step    (step)
  );

  // shared multiplier
  uer_mul_unit u_mul (
    .clk       (clk),
    .en        (mul_en),
    .sel_scale (mul_sel_scale),
    .ticks     (ticks_r),
    .gain      (gain_r),
    .prod      (prod)
  );

  // drop the fraction, clamp at the top of the range
  assign dist_sat = (|prod[PROD_W-1:SCALE_SHIFT+DIST_W]) ? DIST_MAX
                                                          : prod[SCALE_SHIFT+DIST_W-1:SCALE_SHIFT];

  // configuration registers, zero gain writes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= GAIN_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_xfer) begin
      if ((cfg_index == CFG_CAL_GAIN) && (cfg_data != '0)) begin
        gain_r <= cfg_data;
      end
      if (cfg_index == CFG_TIMEOUT) begin
        timeout_r <= cfg_data;
      end
    end
  end

  // sequencer state and kept distance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= SEQ_IDLE;
      last_dist_r <= '0;
    end else begin
      seq_r <= seq_nxt;
      if (dist_load) begin
        last_dist_r <= dist_sat;
      end
    end
  end

  // per-tick result fields captured on the input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_trig_r   <= step.trig;
      res_busy_r   <= step.busy;
      res_done_r   <= step.done;
      res_status_r <= step.status;
      ticks_r      <= step.ticks;
    end
  end

  // sequencer next state and unit controls
  always_comb begin
    seq_nxt       = seq_r;
    mul_en        = 1'b0;
    mul_sel_scale = 1'b0;
    dist_load     = 1'b0;
    case (seq_r)
      SEQ_IDLE: begin
        if (in_xfer) begin
          seq_nxt = step.calc ? SEQ_MUL_GAIN : SEQ_OUT;
        end
      end
      SEQ_MUL_GAIN: begin
        mul_en  = 1'b1;
        seq_nxt = SEQ_MUL_SCALE;
      end
      SEQ_MUL_SCALE: begin
        mul_en        = 1'b1;
        mul_sel_scale = 1'b1;
        seq_nxt       = SEQ_SAT;
      end
      SEQ_SAT: begin
        dist_load = 1'b1;
        seq_nxt   = SEQ_OUT;
      end
      SEQ_OUT: begin
        if (out_tready) begin
          if (in_xfer) begin
            seq_nxt = step.calc ? SEQ_MUL_GAIN : SEQ_OUT;
          end else begin
            seq_nxt = SEQ_IDLE;
          end
        end
      end
      default: begin
        seq_nxt = SEQ_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/uer_mul_unit.sv
module uer_mul_unit (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         sel_scale,
  input  logic [uer_pkg::COUNT_W-1:0]  ticks,
  input  logic [uer_pkg::GAIN_W-1:0]   gain,
  output logic [uer_pkg::PROD_W-1:0]   prod
);
  import uer_pkg::*;

  logic [PROD1_W-1:0] a_op;
  logic [GAIN_W-1:0]  b_op;
  logic [MUL_W-1:0]   full;
  logic [PROD_W-1:0]  prod_r;

  // first pass ticks * gain, second pass partial product * scale constant
  assign a_op = sel_scale ? prod_r[PROD1_W-1:0] : {{GAIN_W{1'b0}}, ticks};
  assign b_op = sel_scale ? SCALE_MUL : gain;
  assign full = {{GAIN_W{1'b0}}, a_op} * {{PROD1_W{1'b0}}, b_op};

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= full[PROD_W-1:0];
    end
  end

  assign prod = prod_r;

endmodule

>>> rtl/uer_phase_ctrl.sv
module uer_phase_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic                        start,
  input  logic                        echo,
  input  logic [uer_pkg::GAIN_W-1:0]  timeout,
  output uer_pkg::step_t              step
);
  import uer_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] cnt_inc;
  logic [COUNT_W-1:0] limit;

  assign cnt_inc = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + COUNT_W'(1);
  assign limit   = {1'b0, timeout};

  // phase register advances once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // tick behavior of each phase
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    step.trig   = 1'b0;
    step.done   = 1'b0;
    step.status = STATUS_OK;
    step.calc   = 1'b0;
    step.ticks  = cnt_r;
    case (phase_r)
      PH_TRIG_LOW: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= TRIG_LOW_TICKS) begin
          phase_nxt = PH_TRIG_HIGH;
          cnt_nxt   = '0;
        end
      end
      PH_TRIG_HIGH: begin
        step.trig = 1'b1;
        cnt_nxt   = cnt_inc;
        if (cnt_inc >= TRIG_HIGH_TICKS) begin
          phase_nxt = PH_WAIT_RISE;
          cnt_nxt   = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          phase_nxt = PH_MEASURE;
          cnt_nxt   = COUNT_W'(1);
        end else begin
          cnt_nxt = cnt_inc;
          if (cnt_inc > limit) begin
            phase_nxt   = PH_IDLE;
            cnt_nxt     = '0;
            step.done   = 1'b1;
            step.status = STATUS_NO_ECHO;
          end
        end
      end
      PH_MEASURE: begin
        if (echo) begin
          cnt_nxt = cnt_inc;
          if (cnt_inc > limit) begin
            phase_nxt   = PH_IDLE;
            cnt_nxt     = '0;
            step.done   = 1'b1;
            step.status = STATUS_TOO_LONG;
          end
        end else begin
          // falling edge closes the pulse, width goes to scaling
          phase_nxt = PH_IDLE;
          cnt_nxt   = '0;
          step.done = 1'b1;
          step.calc = 1'b1;
        end
      end
      default: begin
        if (start) begin
          phase_nxt = PH_TRIG_LOW;
          cnt_nxt   = COUNT_W'(1);
        end else begin
          phase_nxt = PH_IDLE;
          cnt_nxt   = '0;
        end
      end
    endcase
    step.busy = (phase_nxt != PH_IDLE);
  end

endmodule

>>> rtl/uer_checker.sv
`include "ultrasonic_echo_ranger_macros.svh"

module uer_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [uer_pkg::OUT_DATA_W-1:0] out_tdata
);
  import uer_pkg::*;

  // an error status only comes with the end of a measurement
  `UER_ASSERT_IMPL(a_status_needs_done, clk, rst_n, out_tvalid && (out_tdata[4:3] != STATUS_OK), out_tdata[2])

  // a finished measurement is no longer busy
  `UER_ASSERT_IMPL(a_done_not_busy, clk, rst_n, out_tvalid && out_tdata[2], !out_tdata[1])

  // trigger pulse lies inside a running measurement
  `UER_ASSERT_IMPL(a_trig_busy, clk, rst_n, out_tvalid && out_tdata[0], out_tdata[1] && !out_tdata[2])

  // a stalled result stays offered
  `UER_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import uer_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 160;
  localparam int unsigned MAX_REPORTS    = 60;

  // register indexes past the end of the map
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // one microsecond tick as queued for the driver
  typedef struct packed {
    logic start;
    logic echo;
    logic drain;
  } tick_t;

  // result fields, lowest bit last so the struct overlays out_tdata
  typedef struct packed {
    logic [DIST_W-1:0] dist_q8;
    logic [1:0]        status;
    logic              done;
    logic              busy;
    logic              trig;
  } reading_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // [0] start_request, [1] echo_level, [7:2] zero
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [0] trigger_level, [1] busy_res, [2] done_res, [4:3] status, [23:5] distance_q8
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [GAIN_W-1:0]     cfg_data   = '0;

  ultrasonic_echo_ranger dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  tick_t       tick_queue[$];
  reading_t    predicted_readings[$];
  int unsigned queued_items = 0;
  int unsigned fail_count   = 0;

  // ranger state as the predictor sees it
  phase_t             model_phase   = PH_IDLE;
  logic [COUNT_W-1:0] model_count   = '0;
  logic [DIST_W-1:0]  model_dist    = '0;
  logic [GAIN_W-1:0]  model_gain    = GAIN_RESET;
  logic [GAIN_W-1:0]  model_timeout = TIMEOUT_RESET;

  function automatic void bump_count();
    if (model_count != COUNT_MAX) model_count++;
  endfunction

  // advance the ranger by one tick and return the reading it reports
  function automatic reading_t range_tick(logic start, logic echo);
    reading_t    r;
    logic [63:0] prod;
    r = '0;
    case (model_phase)
      PH_TRIG_LOW: begin
        bump_count();
        if (model_count >= TRIG_LOW_TICKS) begin
          model_phase = PH_TRIG_HIGH;
          model_count = '0;
        end
      end
      PH_TRIG_HIGH: begin
        r.trig = 1'b1;
        bump_count();
        if (model_count >= TRIG_HIGH_TICKS) begin
          model_phase = PH_WAIT_RISE;
          model_count = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          model_phase = PH_MEASURE;
          model_count = 17'd1;
        end else begin
          bump_count();
          if (model_count > {1'b0, model_timeout}) begin
            model_phase = PH_IDLE;
            model_count = '0;
            r.done      = 1'b1;
            r.status    = STATUS_NO_ECHO;
          end
        end
      end
      PH_MEASURE: begin
        if (echo) begin
          bump_count();
          if (model_count > {1'b0, model_timeout}) begin
            model_phase = PH_IDLE;
            model_count = '0;
            r.done      = 1'b1;
            r.status    = STATUS_TOO_LONG;
          end
        end else begin
          // ticks * 1124 * gain in Q8 cm, saturated
          prod = (64'(model_count) * 64'(SCALE_MUL) * 64'(model_gain)) >> SCALE_SHIFT;
          model_dist  = (prod > 64'(DIST_MAX)) ? DIST_MAX : prod[DIST_W-1:0];
          model_phase = PH_IDLE;
          model_count = '0;
          r.done      = 1'b1;
          r.status    = STATUS_OK;
        end
      end
      default: begin
        if (start) begin
          model_phase = PH_TRIG_LOW;
          model_count = 17'd1;
        end else begin
          model_phase = PH_IDLE;
          model_count = '0;
        end
      end
    endcase
    r.busy    = (model_phase != PH_IDLE);
    r.dist_q8 = model_dist;
    return r;
  endfunction

  function automatic bit coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // start requests while busy are ignored, so sprinkle a few
  function automatic bit busy_start();
    return ($urandom_range(0, 7) == 0);
  endfunction

  function automatic void push_tick(bit start, bit echo, bit drain);
    tick_queue.push_back('{start, echo, drain});
    queued_items++;
  endfunction

  // start, trigger, echo wait and pulse; cut short where the timeout ends it
  function automatic void push_measurement(int unsigned rise_wait, int unsigned pulse_len,
                                           bit drain);
    int unsigned fail_at;
    push_tick(1'b1, coin(), drain);
    repeat (11) push_tick(busy_start(), coin(), 1'b0);
    fail_at = 32'(model_timeout) + 1;
    if (rise_wait >= fail_at) begin
      repeat (fail_at) push_tick(busy_start(), 1'b0, 1'b0);
      return;
    end
    repeat (rise_wait) push_tick(busy_start(), 1'b0, 1'b0);
    // the rising tick itself is never checked against the timeout
    if (fail_at < 2) fail_at = 2;
    if (pulse_len >= fail_at) begin
      repeat (fail_at) push_tick(busy_start(), 1'b1, 1'b0);
      return;
    end
    repeat (pulse_len) push_tick(busy_start(), 1'b1, 1'b0);
    push_tick(busy_start(), 1'b0, 1'b0);
  endfunction

  // start then random levels, then enough quiet ticks to reach idle again
  function automatic void push_broken();
    int unsigned n;
    n = $urandom_range(1, 40);
    push_tick(1'b1, coin(), 1'b0);
    repeat (n) push_tick(coin(), coin(), 1'b0);
    repeat (32'(model_timeout) + 13) push_tick(1'b0, 1'b0, 1'b0);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // tick driver: bursts with random gaps, optional hold until results drain
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;

  always @(posedge clk) begin
    tick_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready)
        predicted_readings.push_back(range_tick(in_tdata[0], in_tdata[1]));
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (tick_queue.size() != 0 &&
                     !(tick_queue[0].drain && predicted_readings.size() != 0)) begin
          nxt = tick_queue.pop_front();
          in_tdata  <= {{(IN_DATA_W-2){1'b0}}, nxt.echo, nxt.start};
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 5))
              0, 1:    gap_left = 0;
              2:       gap_left = $urandom_range(8, 20);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  logic [7:0]  stall_pat = 8'h00;
  int unsigned stall_age = 0;

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = reading_t'(out_tdata);
        if (predicted_readings.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t unexpected result: expected none, actual %h", $time, out_tdata);
        end else begin
          want = predicted_readings.pop_front();
          check_field("trigger_level", want.trig, got.trig);
          check_field("busy", want.busy, got.busy);
          check_field("done", want.done, got.done);
          check_field("status", want.status, got.status);
          check_field("distance_q8", want.dist_q8, got.dist_q8);
        end
      end
      // a rotating mask that always keeps at least one ready slot
      if (stall_age == 0) begin
        stall_age = $urandom_range(16, 96);
        stall_pat = ($urandom_range(0, 2) == 0) ? 8'h00 : (8'($urandom) & 8'hFE);
      end
      stall_age--;
      stall_pat = {stall_pat[0], stall_pat[7:1]};
      out_tready <= ~stall_pat[0];
    end
  end

  // watchdog on cycles without any transfer
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // a zero gain is refused, spare indexes do nothing
    if (idx == CFG_CAL_GAIN && value != '0) model_gain = value;
    else if (idx == CFG_TIMEOUT) model_timeout = value;
  endtask

  // wait until every queued tick went in and every reading came out
  task automatic wait_quiet();
    while (tick_queue.size() != 0 || in_tvalid || predicted_readings.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int unsigned phase_base;
    int unsigned meas_count;
    int unsigned lim_w;
    int unsigned lim_p;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: echo ignored while idle and during trigger, start ignored while busy
    push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b1, 1'b1, 1'b0);
    for (int i = 0; i < 11; i++) push_tick(i % 3 == 0, i % 2 == 0, 1'b0);
    // one-tick pulse right at the first wait tick
    push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b1, 1'b0, 1'b0);
    push_measurement(3, 5, 1'b1);

    meas_count = 0;
    for (int p = 0; p < 9; p++) begin
      wait_quiet();
      case (p)
        0: begin
          write_reg(CFG_CAL_GAIN, 16'd1);
          write_reg(CFG_TIMEOUT, 16'd0);
        end
        1: begin
          write_reg(CFG_TIMEOUT, 16'd1);
          write_reg(CFG_CAL_GAIN, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_CAL_GAIN, 16'd0);
          write_reg(CFG_SPARE_A, 16'($urandom));
          write_reg(CFG_SPARE_B, 16'($urandom));
          write_reg(CFG_TIMEOUT, 16'd5);
        end
        3: begin
          write_reg(CFG_CAL_GAIN, 16'hFFFF);
          write_reg(CFG_TIMEOUT, 16'hFFFF);
        end
        4: begin
          write_reg(CFG_CAL_GAIN, GAIN_RESET);
          write_reg(CFG_TIMEOUT, 16'd3);
        end
        default: begin
          write_reg(CFG_CAL_GAIN, 16'($urandom_range(1, 65535)));
          write_reg(CFG_TIMEOUT, 16'($urandom_range(0, 60)));
        end
      endcase

      if (p == 3) begin
        // long pulse at full gain drives wide products through the multiplier
        push_measurement(2, 100, 1'b0);
        push_measurement(0, 7, 1'b0);
      end else begin
        lim_w = (model_timeout < 40) ? 32'(model_timeout) + 3 : 40;
        lim_p = (model_timeout < 50) ? 32'(model_timeout) + 3 : 50;
        phase_base = queued_items;
        while (queued_items - phase_base < PHASE_ITEMS) begin
          case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, 4)) push_tick(1'b0, coin(), 1'b0);
            1: if (model_timeout <= 100) push_broken();
            default: begin
              meas_count++;
              push_measurement($urandom_range(0, lim_w), $urandom_range(1, lim_p),
                               meas_count == 3 || $urandom_range(0, 15) == 0);
            end
          endcase
        end
      end
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    if (predicted_readings.size() != 0) begin
      fail_count++;
      $display("%0t missing results: expected %0d more, actual 0",
               $time, predicted_readings.size());
    end
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
